FILE: sv/drtr_pkg.sv
package drtr_pkg;

    localparam int WIDE_W  = 128;
    localparam int HALF_W  = 64;
    localparam int CNT_W   = 6;
    localparam int LIM_POW = 38;
    localparam int MUL_CW  = $clog2(WIDE_W);

    typedef logic [WIDE_W-1:0] t_wide;
    typedef t_wide t_pow_tab [0:LIM_POW];

    localparam t_wide WIDE_MAX = '1;

    // parse sub-phase codes
    localparam logic [2:0] SUB_NONE  = 3'd0;
    localparam logic [2:0] SUB_WHOLE = 3'd1;
    localparam logic [2:0] SUB_FRAC  = 3'd2;
    localparam logic [2:0] SUB_EXP   = 3'd3;
    localparam logic [2:0] SUB_SIGN  = 3'd4;
    localparam logic [2:0] SUB_EDIG  = 3'd5;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef struct packed {
        logic  start;
        t_wide a;
        t_wide b;
    } t_mul_req;

    typedef struct packed {
        logic  busy;
        t_wide p;
    } t_mul_rsp;

    // elaboration-time table of powers of ten
    function automatic t_pow_tab make_pow_tab();
        t_pow_tab tab;
        tab[0] = t_wide'(1);
        for (int k = 1; k <= LIM_POW; k++) begin
            tab[k] = tab[k-1] * t_wide'(10);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW10_TAB = make_pow_tab();

    function automatic t_wide pow10(input logic [CNT_W-1:0] k);
        t_wide r;
        if (k > CNT_W'(LIM_POW)) begin
            r = WIDE_MAX;
        end else begin
            r = POW10_TAB[k];
        end
        return r;
    endfunction

    function automatic t_wide sat_add(input t_wide a, input t_wide b);
        logic [WIDE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIDE_W] ? WIDE_MAX : s[WIDE_W-1:0];
    endfunction

    // acc * 10 + d, saturating on the exact value
    function automatic t_wide digit_step(input t_wide acc, input logic [3:0] d);
        logic [WIDE_W+2:0] s;
        s = {acc, 3'b000} + {2'b00, acc, 1'b0} + {(WIDE_W - 1)'(0), d};
        return (s[WIDE_W+2:WIDE_W] != 3'b000) ? WIDE_MAX : s[WIDE_W-1:0];
    endfunction

endpackage

FILE: sv/drtr_if.sv
interface drtr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface drtr_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [63:0] numerator_high;
    logic [63:0] numerator_low;
    logic [63:0] denominator_high;
    logic [63:0] denominator_low;
    modport source (output valid, output ok, output numerator_high, output numerator_low,
                    output denominator_high, output denominator_low, input ready);
    modport sink   (input valid, input ok, input numerator_high, input numerator_low,
                    input denominator_high, input denominator_low, output ready);
endinterface

FILE: sv/drtr_mul.sv
module drtr_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drtr_pkg::t_mul_req  i_req,
    output drtr_pkg::t_mul_rsp  o_rsp
);
    import drtr_pkg::*;

    logic              r_busy;
    logic [MUL_CW-1:0] r_cnt;
    t_wide             r_acc;
    t_wide             r_a;
    t_wide             r_b;
    logic              r_sat;
    logic [WIDE_W:0]   sum;
    logic              ovf;

    // msb-first shift-add, one multiplier bit per cycle
    always_comb begin
        sum = {1'b0, r_acc[WIDE_W-2:0], 1'b0} + {1'b0, (r_b[WIDE_W-1] ? r_a : '0)};
        ovf = r_acc[WIDE_W-1] | sum[WIDE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_sat  <= 1'b0;
        end else if (r_busy) begin
            r_acc <= sum[WIDE_W-1:0];
            r_sat <= r_sat | ovf;
            r_b   <= {r_b[WIDE_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == MUL_CW'(WIDE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.p    = r_sat ? WIDE_MAX : r_acc;

endmodule

FILE: sv/decimal_ratio_text_to_rational.sv
// a rejected last character gives its result on the next cycle; an accepted one gives
//   it once its multiplies are done and the output slot is free
// a '/' or an accepted last character runs 1 to 4 multiplies on the shared shift-add unit:
//   one per part, two with a nonzero exponent, and two more for the cross product
// throughput: one character per cycle when idle and the output slot is free, else none
// reset: synchronous active-low i_rst_n clears the parser, sequencer and output valid
module decimal_ratio_text_to_rational (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drtr_in_if.sink     i_in,
    drtr_out_if.source  o_out
);
    import drtr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_I1   = 10'b00_0000_0010,
        S_W1   = 10'b00_0000_0100,
        S_I2   = 10'b00_0000_1000,
        S_W2   = 10'b00_0001_0000,
        S_PEND = 10'b00_0010_0000,
        S_I3   = 10'b00_0100_0000,
        S_W3   = 10'b00_1000_0000,
        S_I4   = 10'b01_0000_0000,
        S_W4   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // parse state
    t_wide            r_whole, n_whole;
    t_wide            r_frac, n_frac;
    logic [CNT_W-1:0] r_fcnt, n_fcnt;
    logic [CNT_W-1:0] r_emag, n_emag;
    logic             r_eneg, n_eneg;
    logic             r_part, n_part;
    logic [2:0]       r_sub, n_sub;
    logic             r_err, n_err;
    logic             r_fin, n_fin;
    t_wide            r_fn, n_fn;
    t_wide            r_fd, n_fd;

    // evaluation scratch
    t_wide r_n, n_n;
    t_wide r_d, n_d;
    t_wide r_rn, n_rn;

    // output register
    logic  r_ov, n_ov;
    logic  r_ok, n_ok;
    t_wide r_onum, n_onum;
    t_wide r_oden, n_oden;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic       accept;
    logic       out_free;
    logic [7:0] c;
    logic       is_digit;
    logic [3:0] dig;
    logic [9:0] emul;
    logic       ignore;
    logic       slash_ok;
    logic       end_ok;

    drtr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // output slot is free when empty or being drained this cycle
    assign out_free   = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign c        = i_in.character;
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign dig      = 4'(c - CH_0);
    assign emul     = {4'b0000, r_emag} * 10'd10 + {6'b00_0000, dig};
    assign ignore   = r_err || (c == CH_UNDER);
    // a part may end after whole digits, after the fraction, or after exponent digits
    assign slash_ok = !ignore && (c == CH_SLASH) && !r_part &&
                      (r_sub == SUB_WHOLE || r_sub == SUB_FRAC || r_sub == SUB_EDIG);

    always_comb begin
        n_state = r_state;
        n_whole = r_whole;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_emag  = r_emag;
        n_eneg  = r_eneg;
        n_part  = r_part;
        n_sub   = r_sub;
        n_err   = r_err;
        n_fin   = r_fin;
        n_fn    = r_fn;
        n_fd    = r_fd;
        n_n     = r_n;
        n_d     = r_d;
        n_rn    = r_rn;
        n_ov    = r_ov && !o_out.ready;
        n_ok    = r_ok;
        n_onum  = r_onum;
        n_oden  = r_oden;
        mul_req = '{start: 1'b0, a: r_whole, b: pow10(r_fcnt)};

        // character decode
        if (accept && !ignore) begin
            if (is_digit) begin
                unique case (r_sub)
                    SUB_NONE, SUB_WHOLE: begin
                        n_whole = digit_step(r_whole, dig);
                        n_sub   = SUB_WHOLE;
                    end
                    SUB_FRAC: begin
                        n_frac = digit_step(r_frac, dig);
                        if (r_fcnt != '1) begin
                            n_fcnt = r_fcnt + 1'b1;
                        end
                    end
                    SUB_EXP, SUB_SIGN, SUB_EDIG: begin
                        n_emag = (emul > 10'd63) ? '1 : emul[CNT_W-1:0];
                        n_sub  = SUB_EDIG;
                    end
                    default: n_err = 1'b1;
                endcase
            end else if (c == CH_DOT) begin
                if (r_sub == SUB_NONE || r_sub == SUB_WHOLE) n_sub = SUB_FRAC;
                else n_err = 1'b1;
            end else if (c == CH_LE || c == CH_UE) begin
                if (r_sub == SUB_WHOLE || r_sub == SUB_FRAC) n_sub = SUB_EXP;
                else n_err = 1'b1;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                if (r_sub == SUB_EXP) begin
                    n_eneg = (c == CH_MINUS);
                    n_sub  = SUB_SIGN;
                end else begin
                    n_err = 1'b1;
                end
            end else if (c == CH_SLASH) begin
                // part switch happens once the first part is valued
                if (!slash_ok) n_err = 1'b1;
            end else begin
                n_err = 1'b1;
            end
        end

        // the text can end here only if the decoded character leaves a complete part
        end_ok = !n_err && !(c == CH_SLASH && !ignore) &&
                 (n_sub == SUB_WHOLE || n_sub == SUB_FRAC || n_sub == SUB_EDIG);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.last) begin
                        if (end_ok) begin
                            n_fin   = 1'b1;
                            n_state = S_I1;
                        end else begin
                            // rejected text: zero result, parser back to reset
                            n_ov    = 1'b1;
                            n_ok    = 1'b0;
                            n_onum  = '0;
                            n_oden  = '0;
                            n_whole = '0;
                            n_frac  = '0;
                            n_fcnt  = '0;
                            n_emag  = '0;
                            n_eneg  = 1'b0;
                            n_part  = 1'b0;
                            n_sub   = SUB_NONE;
                            n_err   = 1'b0;
                            n_fn    = '0;
                            n_fd    = '0;
                        end
                    end else if (slash_ok) begin
                        n_fin   = 1'b0;
                        n_state = S_I1;
                    end
                end
            end
            S_I1: begin
                // whole * 10^f
                mul_req = '{start: 1'b1, a: r_whole, b: pow10(r_fcnt)};
                n_state = S_W1;
            end
            S_W1: begin
                if (!mul_rsp.busy) begin
                    n_n     = sat_add(mul_rsp.p, r_frac);
                    n_d     = pow10(r_fcnt);
                    n_state = (r_emag != '0) ? S_I2 : S_PEND;
                end
            end
            S_I2: begin
                // exponent scales the denominator when negative, else the numerator
                mul_req = '{start: 1'b1, a: (r_eneg ? r_d : r_n), b: pow10(r_emag)};
                n_state = S_W2;
            end
            S_W2: begin
                if (!mul_rsp.busy) begin
                    if (r_eneg) n_d = mul_rsp.p;
                    else n_n = mul_rsp.p;
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                if (!r_fin) begin
                    // first part done: store it and start the second part
                    n_fn    = r_n;
                    n_fd    = r_d;
                    n_whole = '0;
                    n_frac  = '0;
                    n_fcnt  = '0;
                    n_emag  = '0;
                    n_eneg  = 1'b0;
                    n_part  = 1'b1;
                    n_sub   = SUB_NONE;
                    n_state = S_IDLE;
                end else if (r_part) begin
                    n_state = S_I3;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_ok    = 1'b1;
                    n_onum  = r_n;
                    n_oden  = r_d;
                    n_whole = '0;
                    n_frac  = '0;
                    n_fcnt  = '0;
                    n_emag  = '0;
                    n_eneg  = 1'b0;
                    n_part  = 1'b0;
                    n_sub   = SUB_NONE;
                    n_err   = 1'b0;
                    n_fn    = '0;
                    n_fd    = '0;
                    n_state = S_IDLE;
                end
            end
            S_I3: begin
                mul_req = '{start: 1'b1, a: r_fn, b: r_d};
                n_state = S_W3;
            end
            S_W3: begin
                if (!mul_rsp.busy) begin
                    n_rn    = mul_rsp.p;
                    n_state = S_I4;
                end
            end
            S_I4: begin
                mul_req = '{start: 1'b1, a: r_fd, b: r_n};
                n_state = S_W4;
            end
            S_W4: begin
                if (!mul_rsp.busy && out_free) begin
                    n_ov    = 1'b1;
                    n_ok    = 1'b1;
                    n_onum  = r_rn;
                    n_oden  = mul_rsp.p;
                    n_whole = '0;
                    n_frac  = '0;
                    n_fcnt  = '0;
                    n_emag  = '0;
                    n_eneg  = 1'b0;
                    n_part  = 1'b0;
                    n_sub   = SUB_NONE;
                    n_err   = 1'b0;
                    n_fn    = '0;
                    n_fd    = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_whole <= '0;
            r_frac  <= '0;
            r_fcnt  <= '0;
            r_emag  <= '0;
            r_eneg  <= 1'b0;
            r_part  <= 1'b0;
            r_sub   <= SUB_NONE;
            r_err   <= 1'b0;
            r_fin   <= 1'b0;
            r_fn    <= '0;
            r_fd    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_whole <= n_whole;
            r_frac  <= n_frac;
            r_fcnt  <= n_fcnt;
            r_emag  <= n_emag;
            r_eneg  <= n_eneg;
            r_part  <= n_part;
            r_sub   <= n_sub;
            r_err   <= n_err;
            r_fin   <= n_fin;
            r_fn    <= n_fn;
            r_fd    <= n_fd;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_d    <= n_d;
        r_rn   <= n_rn;
        r_ok   <= n_ok;
        r_onum <= n_onum;
        r_oden <= n_oden;
    end

    assign o_out.valid            = r_ov;
    assign o_out.ok               = r_ok;
    assign o_out.numerator_high   = r_onum[WIDE_W-1:HALF_W];
    assign o_out.numerator_low    = r_onum[HALF_W-1:0];
    assign o_out.denominator_high = r_oden[WIDE_W-1:HALF_W];
    assign o_out.denominator_low  = r_oden[HALF_W-1:0];

    // no characters are taken while the sequencer is evaluating
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("character accepted during evaluation");

    // a rejected result carries zero values
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |-> (r_onum == '0 && r_oden == '0))
        else $error("rejected result with nonzero value");

    // the multiplier only runs while the sequencer waits on it
    a_mul_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.busy |-> (r_state == S_W1 || r_state == S_W2 ||
                          r_state == S_W3 || r_state == S_W4))
        else $error("multiplier busy outside a wait state");

    // a last character after an error gives its result at once
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last && r_err) |=> (o_out.valid && !o_out.ok))
        else $error("error transaction did not complete");

endmodule
